// ----- rtl/atp_pkg.sv -----
// package for the accelerometer tilt block: widths, transaction and pipeline
// structs, the arctangent step table and the fixed-point helper functions
// no dependencies
package atp_pkg;

   localparam int CORDIC_STEPS = 16;
   localparam int SAMPLE_BITS  = 16;

   localparam int NIB_W      = 4;
   localparam int RAW_W      = 16;
   localparam int GUARD_BITS = 8;
   localparam int SMP_W      = SAMPLE_BITS + GUARD_BITS;
   localparam int XY_W       = SMP_W + 3;
   localparam int EXT_W      = ((SAMPLE_BITS > RAW_W) ? SAMPLE_BITS : RAW_W) + 1;
   localparam int ANG_W      = 32;
   localparam int CDEG_W     = ANG_W + 1 - 16;
   localparam int PITCH_W    = 15;
   localparam int ROLL_W     = 16;
   localparam int TAB_LEN    = 24;
   localparam int TAB_IW     = 5;
   localparam int GAIN_FRAC  = 30;
   localparam int MAG_W      = XY_W - 1;
   localparam int PROD_W     = MAG_W + GAIN_FRAC;

   localparam logic [GAIN_FRAC-1:0] INV_GAIN = 30'd652032874;
   localparam logic [PROD_W:0] ROUND_HALF = (PROD_W + 1)'(1) << (GAIN_FRAC - 1);

   localparam logic signed [ANG_W-1:0]  ANG_90    = 32'sd589824000;
   localparam logic signed [ANG_W-1:0]  ANG_HALF  = 32'sd32768;
   localparam logic signed [CDEG_W-1:0] ROLL_LIM  = 17'sd18000;
   localparam logic signed [CDEG_W-1:0] PITCH_LIM = 17'sd9000;

   localparam logic signed [EXT_W-1:0] SMP_HI = EXT_W'((1 <<< (SAMPLE_BITS - 1)) - 1);
   localparam logic signed [EXT_W-1:0] SMP_LO = EXT_W'(-(1 <<< (SAMPLE_BITS - 1)));

   typedef struct packed {
      logic [NIB_W-1:0]        new_data;
      logic signed [RAW_W-1:0] acc_x;
      logic signed [RAW_W-1:0] acc_y;
      logic signed [RAW_W-1:0] acc_z;
   } req_type;

   typedef struct packed {
      logic signed [PITCH_W-1:0] pitch_cdeg;
      logic signed [ROLL_W-1:0]  roll_cdeg;
   } rsp_type;

   typedef logic signed [SMP_W-1:0]   smp_type;
   typedef logic signed [XY_W-1:0]    xy_type;
   typedef logic signed [ANG_W-1:0]   ang_type;
   typedef logic signed [ROLL_W-1:0]  roll_type;
   typedef logic signed [PITCH_W-1:0] pitch_type;

   typedef struct packed {
      logic      roll_force;
      roll_type  roll;
      logic      pitch_force;
      pitch_type pitch;
      smp_type   yv;
   } side_type;

   typedef struct packed {
      logic     valid;
      xy_type   x;
      xy_type   y;
      ang_type  a;
      side_type side;
   } cell_type;

   typedef struct packed {
      logic              valid;
      logic [PROD_W-1:0] prod;
      side_type          side;
   } gain_type;

   function automatic smp_type sample_in(input logic signed [RAW_W-1:0] raw);
      logic signed [EXT_W-1:0] v;
      v = EXT_W'(raw);
      if (v > SMP_HI) begin
         v = SMP_HI;
      end else if (v < SMP_LO) begin
         v = SMP_LO;
      end
      return {v[SAMPLE_BITS-1:0], GUARD_BITS'(0)};
   endfunction

   function automatic ang_type atan_step(input logic [TAB_IW-1:0] i);
      ang_type r;
      case (i)
         5'd0:  r = 32'sd294912000;
         5'd1:  r = 32'sd174096719;
         5'd2:  r = 32'sd91987925;
         5'd3:  r = 32'sd46694507;
         5'd4:  r = 32'sd23437865;
         5'd5:  r = 32'sd11730358;
         5'd6:  r = 32'sd5866610;
         5'd7:  r = 32'sd2933484;
         5'd8:  r = 32'sd1466764;
         5'd9:  r = 32'sd733385;
         5'd10: r = 32'sd366693;
         5'd11: r = 32'sd183346;
         5'd12: r = 32'sd91673;
         5'd13: r = 32'sd45837;
         5'd14: r = 32'sd22918;
         5'd15: r = 32'sd11459;
         5'd16: r = 32'sd5730;
         5'd17: r = 32'sd2865;
         5'd18: r = 32'sd1432;
         5'd19: r = 32'sd716;
         5'd20: r = 32'sd358;
         5'd21: r = 32'sd179;
         5'd22: r = 32'sd90;
         5'd23: r = 32'sd45;
         default: r = '0;
      endcase
      return r;
   endfunction

   // round half up to whole hundredths, then clamp to +-lim
   function automatic logic signed [CDEG_W-1:0] to_cdeg(input ang_type a,
                                                       input logic signed [CDEG_W-1:0] lim);
      logic signed [ANG_W:0]    s;
      logic signed [CDEG_W-1:0] c;
      s = (ANG_W + 1)'(a) + (ANG_W + 1)'(ANG_HALF);
      c = s[ANG_W:16];
      if (c > lim) begin
         c = lim;
      end else if (c < -lim) begin
         c = -lim;
      end
      return c;
   endfunction

endpackage

// ----- rtl/accel_tilt_pitch_roll.sv -----
// top level: pitch and roll from one accelerometer sample via two cordic cell chains
// depends on atp_pkg, atp_prerot, atp_cordic_cell, atp_gain
//
// Input channel req_valid/req_ready/req_data carries one sample: new_data nibble and
// acc_x, acc_y, acc_z in milli-g. A transaction with a zero nibble is taken and gives
// no result. Any other transaction gives one result on rsp_valid/rsp_ready/rsp_data:
// pitch_cdeg = atan2(y, sqrt(x^2+z^2)) and roll_cdeg = atan2(-x, z), both in
// hundredths of a degree.
// Datapath: input register, fold cell, CORDIC_STEPS iteration cells (roll), two gain
// stages, fold cell, CORDIC_STEPS iteration cells (pitch), output register.
// Throughput: one transaction per cycle while no result is held stalled in the output
// register; every cell advances on each cycle that adv is high.
// When the receiver stalls with a result held in the output register, the whole
// chain freezes and req_ready drops in the same cycle; it returns once rsp_ready is
// seen or the output register empties. Synchronous reset drops every valid bit in
// the chain; nothing in flight survives it, and no result shows after it until a
// new transaction has passed through.
module accel_tilt_pitch_roll (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  atp_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output atp_pkg::rsp_type rsp_data
);
   import atp_pkg::*;

   logic     adv;
   cell_type front_ff;
   cell_type front_in;
   smp_type  xs;
   smp_type  ys;
   smp_type  zs;
   cell_type c1 [CORDIC_STEPS+1];
   cell_type c2 [CORDIC_STEPS+1];
   cell_type g_out;
   logic     rsp_valid_ff;
   logic     rsp_valid_in;
   rsp_type  rsp_ff;
   rsp_type  rsp_in;
   cell_type last;

   assign adv       = !rsp_valid_ff || rsp_ready;
   assign req_ready = adv;

   always_comb begin
      xs = sample_in(req_data.acc_x);
      ys = sample_in(req_data.acc_y);
      zs = sample_in(req_data.acc_z);
      front_in.valid = req_valid && (req_data.new_data != '0);
      front_in.x     = XY_W'(zs);
      front_in.y     = -XY_W'(xs);
      front_in.a     = '0;
      front_in.side.yv = ys;
      front_in.side.roll_force = (xs == 0) || (zs == 0);
      if (xs == 0) begin
         front_in.side.roll = (zs < 0) ? ROLL_W'(-ROLL_LIM) : '0;
      end else begin
         front_in.side.roll = (xs > 0) ? ROLL_W'(-PITCH_LIM) : ROLL_W'(PITCH_LIM);
      end
      front_in.side.pitch_force = (ys == 0) || ((xs == 0) && (zs == 0));
      if (ys == 0) begin
         front_in.side.pitch = '0;
      end else begin
         front_in.side.pitch = (ys > 0) ? PITCH_W'(PITCH_LIM) : PITCH_W'(-PITCH_LIM);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff.valid <= 1'b0;
      end else if (adv) begin
         front_ff <= front_in;
      end
   end

   atp_prerot u_fold_roll (
      .clock (clock),
      .reset (reset),
      .adv   (adv),
      .prev  (front_ff),
      .next  (c1[0])
   );

   for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_roll
      atp_cordic_cell u_cell (
         .clock (clock),
         .reset (reset),
         .adv   (adv),
         .step  (TAB_IW'(k)),
         .prev  (c1[k]),
         .next  (c1[k+1])
      );
   end

   atp_gain u_gain (
      .clock (clock),
      .reset (reset),
      .adv   (adv),
      .prev  (c1[CORDIC_STEPS]),
      .next  (g_out)
   );

   atp_prerot u_fold_pitch (
      .clock (clock),
      .reset (reset),
      .adv   (adv),
      .prev  (g_out),
      .next  (c2[0])
   );

   for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_pitch
      atp_cordic_cell u_cell (
         .clock (clock),
         .reset (reset),
         .adv   (adv),
         .step  (TAB_IW'(k)),
         .prev  (c2[k]),
         .next  (c2[k+1])
      );
   end

   assign last = c2[CORDIC_STEPS];

   always_comb begin
      rsp_valid_in     = last.valid;
      rsp_in.roll_cdeg = last.side.roll;
      if (last.side.pitch_force) begin
         rsp_in.pitch_cdeg = last.side.pitch;
      end else begin
         rsp_in.pitch_cdeg = PITCH_W'(to_cdeg(last.a, PITCH_LIM));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ----- rtl/atp_prerot.sv -----
// quadrant fold ahead of a cordic chain: left half-plane vectors turned by 90 degrees
// depends on atp_pkg
module atp_prerot (
   input  logic              clock,
   input  logic              reset,
   input  logic              adv,
   input  atp_pkg::cell_type prev,
   output atp_pkg::cell_type next
);
   import atp_pkg::*;

   cell_type next_ff;
   cell_type next_in;

   always_comb begin
      next_in = prev;
      if (prev.x < 0) begin
         if (prev.y > 0) begin
            next_in.x = prev.y;
            next_in.y = -prev.x;
            next_in.a = prev.a + ANG_90;
         end else begin
            next_in.x = -prev.y;
            next_in.y = prev.x;
            next_in.a = prev.a - ANG_90;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         next_ff.valid <= 1'b0;
      end else if (adv) begin
         next_ff <= next_in;
      end
   end

   assign next = next_ff;

endmodule

// ----- rtl/atp_cordic_cell.sv -----
// one cordic vectoring iteration, registered; step selects shift and table angle
// depends on atp_pkg
module atp_cordic_cell (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       adv,
   input  logic [atp_pkg::TAB_IW-1:0] step,
   input  atp_pkg::cell_type          prev,
   output atp_pkg::cell_type          next
);
   import atp_pkg::*;

   cell_type next_ff;
   cell_type next_in;
   xy_type   dx;
   xy_type   dy;
   ang_type  da;

   always_comb begin
      dx = prev.x >>> step;
      dy = prev.y >>> step;
      da = atan_step(step);
      next_in = prev;
      if (prev.y >= 0) begin
         next_in.x = prev.x + dy;
         next_in.y = prev.y - dx;
         next_in.a = prev.a + da;
      end else begin
         next_in.x = prev.x - dy;
         next_in.y = prev.y + dx;
         next_in.a = prev.a - da;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         next_ff.valid <= 1'b0;
      end else if (adv) begin
         next_ff <= next_in;
      end
   end

   assign next = next_ff;

endmodule

// ----- rtl/atp_gain.sv -----
// gain correction of the roll magnitude (multiply, then round) and roll angle
// conversion; hands the pitch vector to the second chain. depends on atp_pkg
module atp_gain (
   input  logic              clock,
   input  logic              reset,
   input  logic              adv,
   input  atp_pkg::cell_type prev,
   output atp_pkg::cell_type next
);
   import atp_pkg::*;

   gain_type          mul_ff;
   gain_type          mul_in;
   cell_type          next_ff;
   cell_type          next_in;
   logic [MAG_W-1:0]  mag;
   logic [PROD_W:0]   rnd;

   always_comb begin
      mag = (prev.x < 0) ? '0 : prev.x[MAG_W-1:0];
      mul_in.valid = prev.valid;
      mul_in.prod  = PROD_W'(mag) * PROD_W'(INV_GAIN);
      mul_in.side  = prev.side;
      if (!prev.side.roll_force) begin
         mul_in.side.roll       = ROLL_W'(to_cdeg(prev.a, ROLL_LIM));
         mul_in.side.roll_force = 1'b1;
      end
   end

   always_comb begin
      rnd = {1'b0, mul_ff.prod} + ROUND_HALF;
      next_in.valid = mul_ff.valid;
      next_in.x     = rnd[GAIN_FRAC +: XY_W];
      next_in.y     = XY_W'(mul_ff.side.yv);
      next_in.a     = '0;
      next_in.side  = mul_ff.side;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_ff.valid  <= 1'b0;
         next_ff.valid <= 1'b0;
      end else if (adv) begin
         mul_ff  <= mul_in;
         next_ff <= next_in;
      end
   end

   assign next = next_ff;

endmodule

// ----- rtl/atp_checker.sv -----
// port-level checks for accel_tilt_pitch_roll, attached by the bind at the end
// depends on atp_pkg
module atp_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input atp_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input atp_pkg::rsp_type rsp_data
);
   import atp_pkg::*;

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed or dropped while stalled");

   // angles stay in range
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.pitch_cdeg >= -15'sd9000) && (rsp_data.pitch_cdeg <= 15'sd9000)
                 && (rsp_data.roll_cdeg >= -16'sd18000) && (rsp_data.roll_cdeg <= 16'sd18000))
      else $error("angle out of range");

   // pipeline only blocks on a held result
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid || rsp_ready |-> req_ready)
      else $error("input stalled with output free");

   // reset empties the pipeline
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result present after reset");

endmodule

bind accel_tilt_pitch_roll atp_checker u_atp_checker (.*);

// ----- tb/tb_accel_tilt_pitch_roll.sv -----
// testbench for accel_tilt_pitch_roll: predicts pitch and roll of each sample with a
// nonzero new_data nibble from a 64-bit integer cordic model and checks every response
// transaction in order; depends on atp_pkg and accel_tilt_pitch_roll
module tb_accel_tilt_pitch_roll;

   localparam int     CYCLE_LIMIT  = 500000;
   localparam int     DRAIN_CYCLES = 2 * atp_pkg::CORDIC_STEPS + 20;
   localparam int     ATAN_STEPS   = 24;
   localparam longint QUARTER_TURN = 64'sd9000 * 64'sd65536;
   localparam longint AXIS_HI      = (64'sd1 <<< (atp_pkg::SAMPLE_BITS - 1)) - 1;
   localparam longint AXIS_LO      = -(64'sd1 <<< (atp_pkg::SAMPLE_BITS - 1));
   localparam longint unsigned INV_GAIN_Q30 = 64'd652032874;

   // atan(2^-i) in 1/65536 of a hundredth of a degree
   localparam longint ATAN_UNITS [ATAN_STEPS] = '{
      294912000, 174096719, 91987925, 46694507, 23437865, 11730358,
      5866610, 2933484, 1466764, 733385, 366693, 183346,
      91673, 45837, 22918, 11459, 5730, 2865,
      1432, 716, 358, 179, 90, 45
   };

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_ready;
   atp_pkg::req_type req_data;
   logic             rsp_valid;
   logic             rsp_ready;
   atp_pkg::rsp_type rsp_data;

   atp_pkg::rsp_type expected_angles[$];
   int               mismatch_count;
   int               cycle_count;
   int               stall_left;
   bit               idle_on;

   accel_tilt_pitch_roll u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   function automatic longint axis_scaled(input logic signed [15:0] raw);
      longint v;
      v = longint'(raw);
      if (v > AXIS_HI) v = AXIS_HI;
      if (v < AXIS_LO) v = AXIS_LO;
      return v * 256;
   endfunction

   function automatic void rotate_to_axis(input longint xi, input longint yi,
                                          output longint mag, output longint ang);
      longint x, y, a, dx, dy, t;
      x = xi;
      y = yi;
      a = 0;
      if (x < 0) begin
         t = x;
         if (y > 0) begin
            x = y;
            y = -t;
            a = QUARTER_TURN;
         end else begin
            x = -y;
            y = t;
            a = -QUARTER_TURN;
         end
      end
      for (int i = 0; i < atp_pkg::CORDIC_STEPS && i < ATAN_STEPS; i++) begin
         dx = x >>> i;
         dy = y >>> i;
         if (y >= 0) begin
            x = x + dy;
            y = y - dx;
            a = a + ATAN_UNITS[i];
         end else begin
            x = x - dy;
            y = y + dx;
            a = a - ATAN_UNITS[i];
         end
      end
      mag = x;
      ang = a;
   endfunction

   function automatic longint angle_cdeg(input longint a, input longint lim);
      longint c;
      c = (a + 32768) >>> 16;
      if (c > lim) c = lim;
      if (c < -lim) c = -lim;
      return c;
   endfunction

   function automatic atp_pkg::rsp_type predict_tilt(input atp_pkg::req_type s);
      longint           x, y, z, mag, ang, m2, a2, r, roll, pitch;
      longint unsigned  prod;
      atp_pkg::rsp_type res;
      x = axis_scaled(s.acc_x);
      y = axis_scaled(s.acc_y);
      z = axis_scaled(s.acc_z);
      rotate_to_axis(z, -x, mag, ang);
      if (mag < 0) mag = 0;
      prod = unsigned'(mag) * INV_GAIN_Q30 + (64'd1 << 29);
      r = longint'(prod >> 30);
      if (x == 0) begin
         roll = (z < 0) ? -18000 : 0;
      end else if (z == 0) begin
         roll = (x > 0) ? -9000 : 9000;
      end else begin
         roll = angle_cdeg(ang, 18000);
      end
      if (y == 0) begin
         pitch = 0;
      end else if (x == 0 && z == 0) begin
         pitch = (y > 0) ? 9000 : -9000;
      end else begin
         rotate_to_axis(r, y, m2, a2);
         pitch = angle_cdeg(a2, 9000);
      end
      res.pitch_cdeg = 15'(pitch);
      res.roll_cdeg  = 16'(roll);
      return res;
   endfunction

   function automatic atp_pkg::req_type build_sample(input int nib, input int x,
                                                     input int y, input int z);
      atp_pkg::req_type s;
      s.new_data = 4'(nib);
      s.acc_x    = 16'(x);
      s.acc_y    = 16'(y);
      s.acc_z    = 16'(z);
      return s;
   endfunction

   function automatic logic signed [15:0] random_axis();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
         2, 3, 4: return 16'($urandom);
         default: return 16'(int'($urandom_range(0, 4000)) - 2000);
      endcase
   endfunction

   task automatic send_sample(input atp_pkg::req_type s);
      int gap;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 12);
         @(negedge clock);
         req_valid = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid = 1'b1;
      req_data  = s;
      do @(posedge clock); while (!req_ready);
      if (s.new_data != '0) expected_angles.push_back(predict_tilt(s));
   endtask

   task automatic test_no_new_data();
      send_sample(build_sample(0, 1000, -500, 700));
      send_sample(build_sample(0, 32767, -32768, 0));
      send_sample(build_sample(1, 0, 0, 1000));
      send_sample(build_sample(0, -1, -1, -1));
   endtask

   task automatic test_special_angles();
      send_sample(build_sample(1, 0, 500, -1000));
      send_sample(build_sample(2, 0, -500, 1000));
      send_sample(build_sample(4, 700, 300, 0));
      send_sample(build_sample(8, -700, 300, 0));
      send_sample(build_sample(3, 0, 1000, 0));
      send_sample(build_sample(5, 0, -1000, 0));
      send_sample(build_sample(6, 0, 0, 0));
      send_sample(build_sample(7, 300, 0, -400));
      send_sample(build_sample(9, -600, 200, -800));
      send_sample(build_sample(10, 600, -200, -800));
   endtask

   task automatic test_extremes();
      send_sample(build_sample(15, 32767, 32767, 32767));
      send_sample(build_sample(15, -32768, -32768, -32768));
      send_sample(build_sample(12, -32768, 32767, -32768));
      send_sample(build_sample(13, 32767, -32768, 32767));
      send_sample(build_sample(1, -1, 1, -1));
      send_sample(build_sample(14, 1, -1, 1));
      send_sample(build_sample(11, -32768, 0, 32767));
   endtask

   task automatic test_random_samples(input int count, input bit with_idling);
      atp_pkg::req_type s;
      int               sent;
      sent = 0;
      while (sent < count) begin
         if (with_idling) idle_on = ((sent / 100) % 3) != 2;
         s.new_data = ($urandom_range(0, 7) == 0) ? 4'd0 : 4'($urandom_range(1, 15));
         s.acc_x    = random_axis();
         s.acc_y    = random_axis();
         s.acc_z    = random_axis();
         send_sample(s);
         sent++;
      end
   endtask

   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_ready = 1'b0;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
         stall_left = $urandom_range(0, 11);
         rsp_ready  = 1'b0;
      end else begin
         rsp_ready = 1'b1;
      end
   end

   always @(posedge clock) begin
      atp_pkg::rsp_type exp_rsp;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_angles.size() == 0) begin
            $display("%0t: unexpected transaction, got pitch %0d roll %0d", $time,
                     rsp_data.pitch_cdeg, rsp_data.roll_cdeg);
            mismatch_count++;
         end else begin
            exp_rsp = expected_angles.pop_front();
            if (rsp_data.pitch_cdeg !== exp_rsp.pitch_cdeg) begin
               $display("%0t: pitch_cdeg expected %0d, got %0d", $time,
                        exp_rsp.pitch_cdeg, rsp_data.pitch_cdeg);
               mismatch_count++;
            end
            if (rsp_data.roll_cdeg !== exp_rsp.roll_cdeg) begin
               $display("%0t: roll_cdeg expected %0d, got %0d", $time,
                        exp_rsp.roll_cdeg, rsp_data.roll_cdeg);
               mismatch_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_accel_tilt_pitch_roll failed");
         $finish;
      end
   end

   initial begin
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_data       = '0;
      rsp_ready      = 1'b0;
      idle_on        = 1'b0;
      stall_left     = 0;
      mismatch_count = 0;
      cycle_count    = 0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      idle_on = 1'b1;
      test_no_new_data();
      test_special_angles();
      test_extremes();
      test_random_samples(900, 1'b1);
      idle_on = 1'b0;
      test_random_samples(150, 1'b0);

      @(negedge clock);
      req_valid = 1'b0;
      while (expected_angles.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("tb_accel_tilt_pitch_roll passed");
      end else begin
         $display("tb_accel_tilt_pitch_roll failed");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/atp_pkg.sv
rtl/atp_prerot.sv
rtl/atp_cordic_cell.sv
rtl/atp_gain.sv
rtl/accel_tilt_pitch_roll.sv
rtl/atp_checker.sv
tb/tb_accel_tilt_pitch_roll.sv
